// ===== hw/rtl/nmea_sentence_checker_assert.svh =====
// Assertion macros shared by the sentence checker RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef NMEA_SENTENCE_CHECKER_ASSERT_SVH
`define NMEA_SENTENCE_CHECKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NMEA_CHK_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sentence checker assertion failed");

// Next-cycle implication, checked outside reset.
`define NMEA_CHK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sentence checker assertion failed");

`endif

// ===== hw/rtl/nmea_chk_pkg.sv =====
// Package for the sentence checker: transfer types, result codes and lookups.
// No dependencies; used by nmea_chk_parse and nmea_sentence_checker.
`timescale 1ns / 1ps

package nmea_chk_pkg;

    localparam int IdLen     = 5;
    localparam int KindCount = 10;
    localparam logic [2:0] PosSat = 3'd6;

    localparam logic [7:0] CharDollar = 8'h24;
    localparam logic [7:0] CharStar   = 8'h2A;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_MISMATCH  = 2'd2
    } status_t;

    localparam logic [3:0] KindUnknown = 4'd0;

    localparam logic [8*IdLen-1:0] KindIds [KindCount] = '{
        "GPBOD", "GPGGA", "GPGLL", "GPGSA", "GPGSV",
        "GPRMB", "GPRMC", "PGRME", "PGRMZ", "GPRTE"
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } item_t;

    typedef struct packed {
        status_t    status;
        logic [3:0] kind;
        logic       had_checksum;
        logic [7:0] computed_sum;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.ok    = 1'b1;
        d.value = c[3:0];
        if (c >= 8'h30 && c <= 8'h39) begin
            d.value = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            d.value = c[3:0] + 4'd9;
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

    function automatic logic [3:0] kind_lookup(input logic [8*IdLen-1:0] id);
        logic [3:0] k;
        k = KindUnknown;
        for (int i = 0; i < KindCount; i++) begin
            if (id == KindIds[i]) begin
                k = 4'(i + 1);
            end
        end
        return k;
    endfunction

endpackage

// ===== hw/rtl/nmea_chk_parse.sv =====
// Per-line parsing state of the sentence checker and the result it implies.
// Depends on nmea_chk_pkg.
`timescale 1ns / 1ps

module nmea_chk_parse
    import nmea_chk_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    output result_t result
);

    logic [2:0]         pos_reg, pos_next;
    logic [8*IdLen-1:0] id_reg, id_next;
    logic [7:0]         xor_reg, xor_next;
    logic               star_reg, star_next;
    logic [7:0]         hex_reg, hex_next;
    logic               over_reg, over_next;
    logic               done_reg, done_next;
    logic               bad_reg, bad_next;
    logic               bad_sum;
    hex_digit_t         digit;

    always_comb
    begin
        digit     = hex_decode(item.ch);
        pos_next  = (pos_reg < PosSat) ? pos_reg + 3'd1 : pos_reg;
        id_next   = id_reg;
        xor_next  = xor_reg;
        star_next = star_reg;
        hex_next  = hex_reg;
        over_next = over_reg;
        done_next = done_reg;
        bad_next  = bad_reg;
        if (pos_reg == 3'd0) begin
            bad_next = (item.ch != CharDollar);
        end else begin
            if (pos_reg <= 3'(IdLen)) begin
                id_next = {id_reg[8*IdLen-9:0], item.ch};
            end
            if (!star_reg) begin
                if (item.ch == CharStar) begin
                    star_next = 1'b1;
                end else begin
                    xor_next = xor_reg ^ item.ch;
                end
            end else if (!done_reg) begin
                if (!digit.ok) begin
                    done_next = 1'b1;
                end else begin
                    over_next = over_reg | (|hex_reg[7:4]);
                    hex_next  = {hex_reg[3:0], digit.value};
                end
            end
        end

        bad_sum = star_next && (over_next || hex_next != xor_next);
        if (bad_next) begin
            result.status       = ST_MALFORMED;
            result.kind         = KindUnknown;
            result.had_checksum = 1'b0;
            result.computed_sum = 8'd0;
        end else begin
            result.status       = bad_sum ? ST_MISMATCH : ST_ACCEPTED;
            result.kind         = (bad_sum || pos_next != PosSat) ? KindUnknown
                                                                   : kind_lookup(id_next);
            result.had_checksum = star_next;
            result.computed_sum = xor_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg  <= '0;
            id_reg   <= '0;
            xor_reg  <= '0;
            star_reg <= 1'b0;
            hex_reg  <= '0;
            over_reg <= 1'b0;
            done_reg <= 1'b0;
            bad_reg  <= 1'b0;
        end else if (step) begin
            if (item.last) begin
                pos_reg  <= '0;
                id_reg   <= '0;
                xor_reg  <= '0;
                star_reg <= 1'b0;
                hex_reg  <= '0;
                over_reg <= 1'b0;
                done_reg <= 1'b0;
                bad_reg  <= 1'b0;
            end else begin
                pos_reg  <= pos_next;
                id_reg   <= id_next;
                xor_reg  <= xor_next;
                star_reg <= star_next;
                hex_reg  <= hex_next;
                over_reg <= over_next;
                done_reg <= done_next;
                bad_reg  <= bad_next;
            end
        end
    end

endmodule

// ===== hw/rtl/nmea_sentence_checker.sv =====
// Checks one sentence line per result: leading dollar, XOR checksum and identifier.
// Characters arrive one per transfer, with the last flag on the final character of a
// line, and a new character can be taken in every cycle unless the input stalls. The
// result of a line is loaded into the output register when its last character leaves
// the input register, and it is offered from the output register.
// While a result waits, the last character of the next line is held in the input
// register and the input stalls until the result is taken. Depends on nmea_chk_pkg and
// nmea_chk_parse.
`timescale 1ns / 1ps
`include "nmea_sentence_checker_assert.svh"

module nmea_sentence_checker
    import nmea_chk_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic    in_vld_reg, in_vld_next;
    item_t   in_item_reg;
    logic    out_vld_reg, out_vld_next;
    result_t out_item_reg;
    result_t parse_result;
    logic    out_free;
    logic    advance;
    logic    take;

    assign out_free   = !out_vld_reg || !result_stall;
    assign advance    = in_vld_reg && (!in_item_reg.last || out_free);
    assign item_stall = in_vld_reg && !advance;
    assign take       = item_valid && !item_stall;

    assign result_valid = out_vld_reg;
    assign result       = out_item_reg;

    nmea_chk_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .result (parse_result)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (take) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance && in_item_reg.last) begin
            out_vld_next = 1'b1;
        end else if (!result_stall) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            in_item_reg <= item;
        end
        if (advance && in_item_reg.last) begin
            out_item_reg <= parse_result;
        end
    end

    `NMEA_CHK_ASSERT_NOW(a_stall_needs_item, item_stall, in_vld_reg && in_item_reg.last)
    `NMEA_CHK_ASSERT_NEXT(a_last_gives_result, advance && in_item_reg.last, result_valid)
    `NMEA_CHK_ASSERT_NOW(a_malformed_clear, result_valid && result.status == ST_MALFORMED,
        result.kind == KindUnknown && !result.had_checksum && result.computed_sum == 8'd0)
    `NMEA_CHK_ASSERT_NOW(a_mismatch_has_star, result_valid && result.status == ST_MISMATCH,
        result.kind == KindUnknown && result.had_checksum)
    `NMEA_CHK_ASSERT_NOW(a_kind_range, result_valid, result.kind <= 4'(KindCount))

endmodule
